FILE: rtl/iprot_pkg.sv
// ---------------------------------------------------------------------------
// iprot_pkg: shared types and constants of the ionospheric phase rotator
// Widths, scale constants, the CORDIC arctangent table and the records that
// travel along the cell chains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iprot_pkg;

  localparam int SAMPLE_WIDTH  = 24;
  localparam int CORDIC_STAGES = 20;

  localparam int DTEC_W  = 24;
  localparam int COEFF_W = 40;
  localparam int CFG_W   = 40;
  localparam int CFG_IDX_W = 1;
  localparam int SKY_W   = 27;
  localparam int BW_W    = 20;
  localparam int PHASE_W = 40;

  // centre in 500 Hz units, signed
  localparam int C2_W   = SKY_W + 3;
  localparam int C2M_W  = C2_W - 1;
  localparam int HALF_W = COEFF_W / 2;
  localparam int PP_W   = HALF_W + DTEC_W;
  localparam int P_W    = 64;
  localparam int DD_W   = 42;
  localparam int N_W    = P_W + 11;
  localparam int Q_W    = PHASE_W + 1;

  // binary angle long division by 45
  localparam int NIB_W     = 4;
  localparam int V_W       = 56;
  localparam int D45_CELLS = V_W / NIB_W;
  localparam int R45_W     = 6;
  localparam int AQ_W      = 32;
  localparam int ANG_SHIFT = 13;

  localparam int XW = SAMPLE_WIDTH + 18;
  localparam int ZW = AQ_W + 2;
  localparam int KW = 5;
  localparam int GAIN_SHIFT = 14;
  localparam int OUT_SHIFT  = 16;

  localparam logic [13:0]      CENTRE_SCALE = 14'd8875;
  localparam logic [9:0]       DEG_SCALE    = 10'd1017;
  localparam logic [R45_W:0]   ANG_DIV      = 7'd45;
  localparam logic [4:0]       ANG_BIAS     = 5'd22;
  localparam logic signed [30:0] CORDIC_GAIN = 31'sd652032874;

  localparam logic [Q_W-1:0] PH_NEG_MAG = Q_W'(1) << (PHASE_W - 1);
  localparam logic [Q_W-1:0] PH_POS_MAG = PH_NEG_MAG - Q_W'(1);

  localparam logic signed [XW-1:0] SMP_MAX = XW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic signed [XW-1:0] OUT_RND = XW'(64'sd1 <<< (OUT_SHIFT - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DTEC  = 1'b0,
    REG_COEFF = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_real;
    logic signed [SAMPLE_WIDTH-1:0] sample_imag;
    logic [SKY_W-1:0]               sky_freq_khz;
    logic [BW_W-1:0]                bandwidth_khz;
    logic                           upper_sideband;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] rot_real;
    logic signed [SAMPLE_WIDTH-1:0] rot_imag;
    logic signed [PHASE_W-1:0]      phase_deg;
    logic                           saturated;
  } out_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
    logic                           neg;
    logic                           zero;
    logic                           pzero;
    logic                           sat;
    logic [PHASE_W-1:0]             phase;
  } tag_t;

  typedef struct packed {
    logic [DD_W-1:0] rem;
    logic [Q_W-1:0]  low;
    logic [Q_W-1:0]  quo;
    logic [DD_W-1:0] dd;
    logic            ovf;
    tag_t            tag;
  } div_t;

  typedef struct packed {
    logic [R45_W-1:0] rem;
    logic [V_W-1:0]   low;
    logic [AQ_W-1:0]  quo;
    tag_t             tag;
  } a45_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    tag_t                 tag;
  } cor_t;

  // atan(2^-k) as a fraction of a full turn, 2^32 per turn
  function automatic logic [AQ_W-1:0] atan_turn(input logic [KW-1:0] k);
    logic [AQ_W-1:0] t;
    case (k)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/iprot_if.sv
// ---------------------------------------------------------------------------
// iprot_if: stream channels of the ionospheric phase rotator
// Input beat carries a visibility sample and its channel description, output
// beat the rotated sample, the phase and the saturation flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iprot_in_if;
  import iprot_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_real;
  logic signed [SAMPLE_WIDTH-1:0] sample_imag;
  logic [SKY_W-1:0]               sky_freq_khz;
  logic [BW_W-1:0]                bandwidth_khz;
  logic                           upper_sideband;

  modport source (output valid, sample_real, sample_imag, sky_freq_khz, bandwidth_khz,
                  upper_sideband, input ready);
  modport sink   (input valid, sample_real, sample_imag, sky_freq_khz, bandwidth_khz,
                  upper_sideband, output ready);
endinterface

interface iprot_out_if;
  import iprot_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] rot_real;
  logic signed [SAMPLE_WIDTH-1:0] rot_imag;
  logic signed [PHASE_W-1:0]      phase_deg;
  logic                           saturated;

  modport source (output valid, rot_real, rot_imag, phase_deg, saturated, input ready);
  modport sink   (input valid, rot_real, rot_imag, phase_deg, saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/iprot_front.sv
// ---------------------------------------------------------------------------
// iprot_front: centre frequency and dividend set-up
// Forms the channel centre, coeff*|dtec| in two half products, the scaled
// divisor and dividend, and the overflow test ahead of the divider chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprot_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  iprot_pkg::in_t                 in_i,
  input  logic [iprot_pkg::DTEC_W-1:0]   dtec_i,
  input  logic [iprot_pkg::COEFF_W-1:0]  coeff_i,
  output logic                           valid_o,
  output iprot_pkg::div_t                div_o
);
  import iprot_pkg::*;

  // stage a
  logic [C2_W-1:0]  sky2, bwx, c2u;
  logic             c2neg, dneg, zero_d, pzero_d;
  logic [C2M_W-1:0] c2m_d;
  logic [DTEC_W-1:0] dm;
  logic [PP_W-1:0]  pplo_d, pphi_d;
  tag_t             tag_d;

  logic             va_q;
  logic [PP_W-1:0]  pplo_q, pphi_q;
  logic [C2M_W-1:0] c2m_q;
  tag_t             taga_q;

  // stage b
  logic             vb_q;
  logic [P_W-1:0]   p_d, p_q;
  logic [DD_W-1:0]  dd_d, ddb_q;
  tag_t             tagb_q;

  // stage c
  logic             vc_q;
  logic [N_W-1:0]   n_d, n_q;
  logic [DD_W-1:0]  ddc_q;
  tag_t             tagc_q;

  // stage d
  div_t             div_d;
  logic             vd_q;
  div_t             div_q;

  always_comb begin
    sky2    = {2'b00, in_i.sky_freq_khz, 1'b0};
    bwx     = C2_W'(in_i.bandwidth_khz);
    c2u     = in_i.upper_sideband ? (sky2 + bwx) : (sky2 - bwx);
    c2neg   = c2u[C2_W-1];
    c2m_d   = c2neg ? C2M_W'(C2_W'(0) - c2u) : c2u[C2M_W-1:0];
    zero_d  = (c2u == '0);
    dneg    = dtec_i[DTEC_W-1];
    dm      = dneg ? (DTEC_W'(0) - dtec_i) : dtec_i;
    pzero_d = (coeff_i == '0) || (dtec_i == '0);
    pplo_d  = PP_W'(coeff_i[HALF_W-1:0]) * PP_W'(dm);
    pphi_d  = PP_W'(coeff_i[COEFF_W-1:HALF_W]) * PP_W'(dm);

    tag_d       = '0;
    tag_d.re    = in_i.sample_real;
    tag_d.im    = in_i.sample_imag;
    tag_d.zero  = zero_d;
    tag_d.pzero = pzero_d;
    // zero centre keeps the sign of dtec
    tag_d.neg   = zero_d ? dneg : ((dneg ^ c2neg) & ~pzero_d);
  end

  always_comb begin
    p_d  = {pphi_q, HALF_W'(0)} + P_W'(pplo_q);
    dd_d = DD_W'(c2m_q * CENTRE_SCALE);
    n_d  = N_W'(p_q) * N_W'(DEG_SCALE) + N_W'(ddb_q >> 1);
  end

  always_comb begin
    div_d     = '0;
    div_d.rem = DD_W'(n_q[N_W-1:Q_W]);
    div_d.low = n_q[Q_W-1:0];
    div_d.dd  = ddc_q;
    div_d.ovf = (DD_W'(n_q[N_W-1:Q_W]) >= ddc_q);
    div_d.tag = tagc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pplo_q <= pplo_d;
      pphi_q <= pphi_d;
      c2m_q  <= c2m_d;
      taga_q <= tag_d;
      p_q    <= p_d;
      ddb_q  <= dd_d;
      tagb_q <= taga_q;
      n_q    <= n_d;
      ddc_q  <= ddb_q;
      tagc_q <= tagb_q;
      div_q  <= div_d;
    end
  end

  assign valid_o = vd_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

FILE: rtl/iprot_div_cell.sv
// ---------------------------------------------------------------------------
// iprot_div_cell: one restoring division cell
// Brings down one dividend bit, compares against the divisor and passes the
// partial remainder and quotient to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprot_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  iprot_pkg::div_t  div_i,
  output logic             valid_o,
  output iprot_pkg::div_t  div_o
);
  import iprot_pkg::*;

  logic [DD_W:0] trial, dvs, diff;
  logic          ge;
  div_t          div_d, div_q;
  logic          valid_q;

  always_comb begin
    trial     = {div_i.rem, div_i.low[Q_W-1]};
    dvs       = {1'b0, div_i.dd};
    diff      = trial - dvs;
    ge        = (trial >= dvs);
    div_d     = div_i;
    div_d.rem = ge ? diff[DD_W-1:0] : trial[DD_W-1:0];
    div_d.low = {div_i.low[Q_W-2:0], 1'b0};
    div_d.quo = {div_i.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

FILE: rtl/iprot_d45_cell.sv
// ---------------------------------------------------------------------------
// iprot_d45_cell: one nibble of the long division by 45
// Turns degrees into a binary angle four quotient bits at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprot_d45_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  iprot_pkg::a45_t  a_i,
  output logic             valid_o,
  output iprot_pkg::a45_t  a_o
);
  import iprot_pkg::*;

  logic [R45_W-1:0] r;
  logic [R45_W:0]   t;
  logic [NIB_W-1:0] qn;
  a45_t             a_d, a_q;
  logic             valid_q;

  always_comb begin
    r  = a_i.rem;
    qn = '0;
    for (int i = 0; i < NIB_W; i++) begin
      t = {r, a_i.low[V_W-1-i]};
      if (t >= ANG_DIV) begin
        r             = R45_W'(t - ANG_DIV);
        qn[NIB_W-1-i] = 1'b1;
      end else begin
        r = t[R45_W-1:0];
      end
    end
    a_d     = a_i;
    a_d.rem = r;
    a_d.low = a_i.low << NIB_W;
    a_d.quo = {a_i.quo[AQ_W-NIB_W-1:0], qn};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;

endmodule

`default_nettype wire

FILE: rtl/iprot_cordic_cell.sv
// ---------------------------------------------------------------------------
// iprot_cordic_cell: one CORDIC micro-rotation
// Rotates by +/- atan(2^-k) towards zero residual angle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprot_cordic_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [iprot_pkg::KW-1:0]  k_i,
  input  logic                      valid_i,
  input  iprot_pkg::cor_t           c_i,
  output logic                      valid_o,
  output iprot_pkg::cor_t           c_o
);
  import iprot_pkg::*;

  logic signed [XW-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z, at;
  cor_t                 c_d, c_q;
  logic                 valid_q;

  always_comb begin
    x   = c_i.x;
    y   = c_i.y;
    z   = c_i.z;
    xs  = x >>> k_i;
    ys  = y >>> k_i;
    at  = $signed(ZW'(atan_turn(k_i)));
    c_d = c_i;
    if (!z[ZW-1]) begin
      c_d.x = x - ys;
      c_d.y = y + xs;
      c_d.z = z - at;
    end else begin
      c_d.x = x + ys;
      c_d.y = y - xs;
      c_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;

endmodule

`default_nettype wire

FILE: rtl/ionospheric_phase_rotator.sv
// ---------------------------------------------------------------------------
// ionospheric_phase_rotator: dispersive ionospheric phase correction
// Phase = coeff*dTEC/centre in degrees, sample rotated by exp(i*phase).
//
//   channel  dir  beat contents
//   in_i     in   sample_real, sample_imag, sky_freq_khz, bandwidth_khz,
//                 upper_sideband
//   out_o    out  rot_real, rot_imag, phase_deg, saturated
//   cfg_*    in   reg 0 dtec, reg 1 iono_coeff, one write per cycle
//
// one beat per cycle while in_i.ready is high; a beat passes the front stages,
// 41 divider cells, 14 angle cells, the CORDIC cells and the output register
// the whole chain advances together; an output register plus a skid slot let
// one more beat in while a result is held, then in_i.ready drops
// reset clears the valid bits, the skid and both config registers to zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ionospheric_phase_rotator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  iprot_in_if.sink                         in_i,
  iprot_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [iprot_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iprot_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import iprot_pkg::*;

  logic [DTEC_W-1:0]  dtec_q;
  logic [COEFF_W-1:0] coeff_q;

  logic en;
  in_t  in_pl;

  logic [Q_W:0] div_v;
  div_t         div_s [Q_W+1];

  a45_t           e_d;
  logic [Q_W:0]   lim, mag41;
  logic [PHASE_W-1:0] mag;
  logic           sat_e;

  logic [D45_CELLS:0] a_v;
  a45_t               a_s [D45_CELLS+1];

  logic                               vf_q;
  logic signed [SAMPLE_WIDTH+30:0]    px_d, py_d, px_q, py_q;
  logic [AQ_W-1:0]                    ang_d, ang_q;
  tag_t                               tagf_q;

  cor_t                   g_d;
  logic signed [XW-1:0]   gx, gy;
  logic [AQ_W-1:0]        angf;

  logic [CORDIC_STAGES:0] c_v;
  cor_t                   c_s [CORDIC_STAGES+1];

  logic [SAMPLE_WIDTH:0] rx, ry;
  out_t                  res;

  logic out_v_q, skid_v_q, pop;
  out_t out_q, skid_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtec_q  <= '0;
      coeff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DTEC:  dtec_q  <= cfg_wdata_i[DTEC_W-1:0];
        REG_COEFF: coeff_q <= cfg_wdata_i[COEFF_W-1:0];
        default:   ;
      endcase
    end
  end

  assign en         = ~skid_v_q;
  assign in_i.ready = en;

  always_comb begin
    in_pl.sample_real    = in_i.sample_real;
    in_pl.sample_imag    = in_i.sample_imag;
    in_pl.sky_freq_khz   = in_i.sky_freq_khz;
    in_pl.bandwidth_khz  = in_i.bandwidth_khz;
    in_pl.upper_sideband = in_i.upper_sideband;
  end

  iprot_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .in_i    (in_pl),
    .dtec_i  (dtec_q),
    .coeff_i (coeff_q),
    .valid_o (div_v[0]),
    .div_o   (div_s[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    iprot_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[i]),
      .div_i   (div_s[i]),
      .valid_o (div_v[i+1]),
      .div_o   (div_s[i+1])
    );
  end

  // phase magnitude, clamping, degrees scaled for the angle division
  always_comb begin
    lim   = {1'b0, (div_s[Q_W].tag.neg ? PH_NEG_MAG : PH_POS_MAG)};
    sat_e = 1'b0;
    if (div_s[Q_W].tag.zero) begin
      mag41 = div_s[Q_W].tag.pzero ? '0 : lim;
      sat_e = 1'b1;
    end else if (div_s[Q_W].ovf || ({1'b0, div_s[Q_W].quo} > lim)) begin
      mag41 = lim;
      sat_e = 1'b1;
    end else begin
      mag41 = {1'b0, div_s[Q_W].quo};
    end
    mag           = mag41[PHASE_W-1:0];
    e_d           = '0;
    e_d.tag       = div_s[Q_W].tag;
    e_d.tag.sat   = sat_e;
    e_d.tag.phase = div_s[Q_W].tag.neg ? (PHASE_W'(0) - mag) : mag;
    e_d.low       = (V_W'(mag) << ANG_SHIFT) + V_W'(ANG_BIAS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v[0] <= 1'b0;
    end else if (en) begin
      a_v[0] <= div_v[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_s[0] <= e_d;
    end
  end

  for (genvar i = 0; i < D45_CELLS; i++) begin : g_d45
    iprot_d45_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (a_v[i]),
      .a_i     (a_s[i]),
      .valid_o (a_v[i+1]),
      .a_o     (a_s[i+1])
    );
  end

  // gain prescale and signed binary angle
  always_comb begin
    px_d  = $signed(a_s[D45_CELLS].tag.re) * CORDIC_GAIN;
    py_d  = $signed(a_s[D45_CELLS].tag.im) * CORDIC_GAIN;
    ang_d = a_s[D45_CELLS].tag.neg ? (AQ_W'(0) - a_s[D45_CELLS].quo) : a_s[D45_CELLS].quo;
  end

  // fold second and third quadrants by negating the sample
  always_comb begin
    gx   = XW'(px_q >>> GAIN_SHIFT);
    gy   = XW'(py_q >>> GAIN_SHIFT);
    angf = ang_q;
    g_d  = '0;
    if (ang_q[AQ_W-1] ^ ang_q[AQ_W-2]) begin
      gx   = -gx;
      gy   = -gy;
      angf = {~ang_q[AQ_W-1], ang_q[AQ_W-2:0]};
    end
    g_d.x   = gx;
    g_d.y   = gy;
    g_d.z   = ZW'($signed(angf));
    g_d.tag = tagf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q   <= 1'b0;
      c_v[0] <= 1'b0;
    end else if (en) begin
      vf_q   <= a_v[D45_CELLS];
      c_v[0] <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= px_d;
      py_q   <= py_d;
      ang_q  <= ang_d;
      tagf_q <= a_s[D45_CELLS].tag;
      c_s[0] <= g_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
    iprot_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .k_i     (KW'(i)),
      .valid_i (c_v[i]),
      .c_i     (c_s[i]),
      .valid_o (c_v[i+1]),
      .c_o     (c_s[i+1])
    );
  end

  // round half up, drop the guard bits, clamp; top bit is the clamp flag
  function automatic logic [SAMPLE_WIDTH:0] round_clamp(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    s = v + OUT_RND;
    s = s >>> OUT_SHIFT;
    if (s > SMP_MAX) begin
      return {1'b1, SMP_MAX[SAMPLE_WIDTH-1:0]};
    end else if (s < SMP_MIN) begin
      return {1'b1, SMP_MIN[SAMPLE_WIDTH-1:0]};
    end
    return {1'b0, s[SAMPLE_WIDTH-1:0]};
  endfunction

  always_comb begin
    rx            = round_clamp(c_s[CORDIC_STAGES].x);
    ry            = round_clamp(c_s[CORDIC_STAGES].y);
    res.rot_real  = rx[SAMPLE_WIDTH-1:0];
    res.rot_imag  = ry[SAMPLE_WIDTH-1:0];
    res.phase_deg = c_s[CORDIC_STAGES].tag.phase;
    res.saturated = c_s[CORDIC_STAGES].tag.sat | rx[SAMPLE_WIDTH] | ry[SAMPLE_WIDTH];
  end

  // output register with a skid slot behind it
  assign pop = out_v_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (c_v[CORDIC_STAGES]) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (c_v[CORDIC_STAGES]) begin
      if (!out_v_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.rot_real  = out_q.rot_real;
  assign out_o.rot_imag  = out_q.rot_imag;
  assign out_o.phase_deg = out_q.phase_deg;
  assign out_o.saturated = out_q.saturated;

endmodule

`default_nettype wire

FILE: rtl/iprot_chk.sv
// ---------------------------------------------------------------------------
// iprot_chk: port-level checks of the ionospheric phase rotator
// Watches the stream ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprot_chk (
  input logic                                        clk_i,
  input logic                                        rst_ni,
  input logic                                        in_ready_i,
  input logic                                        out_valid_i,
  input logic                                        out_ready_i,
  input logic [2*iprot_pkg::SAMPLE_WIDTH+iprot_pkg::PHASE_W:0] out_data_i
);
  import iprot_pkg::*;

  // a held beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // a held beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output payload changed while stalled");

  // input back-pressure only follows a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid after reset");

endmodule

bind ionospheric_phase_rotator iprot_chk u_iprot_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  ({out_o.rot_real, out_o.rot_imag, out_o.phase_deg, out_o.saturated})
);

`default_nettype wire
